// ===== rtl/met_pkg.sv =====
// shared types, widths and register codes for the matrix exponential block
// no dependencies; imported by the controller, the datapath and the top level
package met_pkg;

   localparam int DATA_W      = 32;
   localparam int DIM_CFG_W   = 4;
   localparam int TERMS_CFG_W = 6;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_IDX_W-1:0] REG_DIM   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TERMS = 2'd1;

   typedef struct packed {
      logic load_we;
      logic clr_sat;
      logic init_wr;
      logic diag;
      logic one_term;
      logic acc_clr;
      logic mul;
      logic acc;
      logic div_start;
      logic div_step;
      logic upd_wr;
      logic out_load;
      logic out_last;
   } met_cmd_type;

   typedef struct packed {
      logic rsp_taken;
   } met_status_type;

   // saturate to 32 bits, flag in the top bit
   function automatic logic [DATA_W:0] sat32(input logic signed [63:0] v);
      logic [DATA_W:0] r;
      if (v > 64'sd2147483647) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -64'sd2147483648) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[DATA_W-1:0]};
      end
      return r;
   endfunction

endpackage

// ===== rtl/met_ctrl.sv =====
// sequencer for the matrix exponential block: configuration, counters and states
// depends on met_pkg; drives the datapath by command and address signals
module met_ctrl #(
   parameter int MAX_DIM   = 8,
   parameter int MAX_TERMS = 32,
   localparam int IDX_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
   localparam int CELLS    = MAX_DIM * MAX_DIM,
   localparam int ADDR_W   = (CELLS > 1) ? $clog2(CELLS) : 1,
   localparam int KW       = $clog2(MAX_TERMS + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [met_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [met_pkg::CSR_DATA_W-1:0]    csr_data,
   input  met_pkg::met_status_type           status,
   output met_pkg::met_cmd_type              cmd,
   output logic [ADDR_W-1:0]                 load_addr,
   output logic [ADDR_W-1:0]                 cell_addr,
   output logic [ADDR_W-1:0]                 src_raddr,
   output logic [ADDR_W-1:0]                 trm_raddr,
   output logic                              trm_rbank,
   output logic                              trm_wbank,
   output logic [KW-1:0]                     k_value
);
   import met_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int DC_W  = $clog2(DATA_W);

   typedef enum logic [12:0] {
      ST_LOAD      = 13'h0001,
      ST_INIT_RD   = 13'h0002,
      ST_INIT_WR   = 13'h0004,
      ST_MAC_RD    = 13'h0008,
      ST_MAC_MUL   = 13'h0010,
      ST_MAC_ACC   = 13'h0020,
      ST_DIV_START = 13'h0040,
      ST_DIV       = 13'h0080,
      ST_UPD_RD    = 13'h0100,
      ST_UPD_WR    = 13'h0200,
      ST_OUT_RD    = 13'h0400,
      ST_OUT_LOAD  = 13'h0800,
      ST_OUT_WAIT  = 13'h1000
   } state_type;

   state_type state_ff, state_in;
   logic [DIM_CFG_W-1:0]   dim_ff, dim_in;
   logic [TERMS_CFG_W-1:0] terms_ff, terms_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, m_ff, m_in, li_ff, li_in, lj_ff, lj_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [DC_W-1:0]  dcnt_ff, dcnt_in;
   logic             bank_ff, bank_in;
   logic [DIM_W-1:0] n_eff;
   logic [KW-1:0]    t_eff;
   logic [IDX_W-1:0] nm1;
   logic             cell_end, load_end, csr_we;

   function automatic logic [ADDR_W-1:0] cell_idx(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
      return ADDR_W'(int'(r) * MAX_DIM + int'(c));
   endfunction

   always_comb begin
      if (dim_ff == '0) begin
         n_eff = DIM_W'(1);
      end else if (int'(dim_ff) > MAX_DIM) begin
         n_eff = DIM_W'(MAX_DIM);
      end else begin
         n_eff = DIM_W'(dim_ff);
      end
      if (terms_ff == '0) begin
         t_eff = KW'(1);
      end else if (int'(terms_ff) > MAX_TERMS) begin
         t_eff = KW'(MAX_TERMS);
      end else begin
         t_eff = KW'(terms_ff);
      end
   end

   assign nm1       = IDX_W'(n_eff - DIM_W'(1));
   assign cell_end  = (i_ff == nm1) && (j_ff == nm1);
   assign load_end  = (li_ff == nm1) && (lj_ff == nm1);
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;
   assign req_tready = (state_ff == ST_LOAD);

   assign load_addr = cell_idx(li_ff, lj_ff);
   assign cell_addr = cell_idx(i_ff, j_ff);
   assign src_raddr = (state_ff == ST_MAC_RD) ? cell_idx(m_ff, j_ff) : cell_idx(i_ff, j_ff);
   assign trm_raddr = cell_idx(i_ff, m_ff);
   assign trm_rbank = bank_ff;
   assign trm_wbank = (state_ff == ST_INIT_WR) ? 1'b0 : ~bank_ff;
   assign k_value   = k_ff;

   always_comb begin
      state_in = state_ff;
      dim_in   = dim_ff;
      terms_in = terms_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      m_in     = m_ff;
      li_in    = li_ff;
      lj_in    = lj_ff;
      k_in     = k_ff;
      dcnt_in  = dcnt_ff;
      bank_in  = bank_ff;
      cmd      = '0;
      cmd.diag     = (i_ff == j_ff);
      cmd.one_term = (t_eff == KW'(1));
      cmd.out_last = cell_end;

      case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               cmd.load_we = 1'b1;
               if (load_end) begin
                  li_in       = '0;
                  lj_in       = '0;
                  i_in        = '0;
                  j_in        = '0;
                  cmd.clr_sat = 1'b1;
                  state_in    = ST_INIT_RD;
               end else if (lj_ff == nm1) begin
                  lj_in = '0;
                  li_in = li_ff + 1'b1;
               end else begin
                  lj_in = lj_ff + 1'b1;
               end
            end
         end
         ST_INIT_RD: state_in = ST_INIT_WR;
         ST_INIT_WR: begin
            cmd.init_wr = 1'b1;
            state_in    = ST_INIT_RD;
            if (cell_end) begin
               i_in    = '0;
               j_in    = '0;
               m_in    = '0;
               bank_in = 1'b0;
               k_in    = KW'(2);
               state_in = (t_eff <= KW'(2)) ? ST_OUT_RD : ST_MAC_RD;
            end else if (j_ff == nm1) begin
               j_in = '0;
               i_in = i_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_MAC_RD: begin
            cmd.acc_clr = (m_ff == '0);
            state_in    = ST_MAC_MUL;
         end
         ST_MAC_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_MAC_ACC;
         end
         ST_MAC_ACC: begin
            cmd.acc = 1'b1;
            if (m_ff == nm1) begin
               m_in     = '0;
               state_in = ST_DIV_START;
            end else begin
               m_in     = m_ff + 1'b1;
               state_in = ST_MAC_RD;
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            dcnt_in       = '0;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            dcnt_in      = dcnt_ff + 1'b1;
            if (dcnt_ff == DC_W'(DATA_W - 1)) begin
               state_in = ST_UPD_RD;
            end
         end
         ST_UPD_RD: state_in = ST_UPD_WR;
         ST_UPD_WR: begin
            cmd.upd_wr = 1'b1;
            state_in   = ST_MAC_RD;
            if (cell_end) begin
               i_in    = '0;
               j_in    = '0;
               bank_in = ~bank_ff;
               if (k_ff + KW'(1) == t_eff) begin
                  state_in = ST_OUT_RD;
               end else begin
                  k_in = k_ff + KW'(1);
               end
            end else if (j_ff == nm1) begin
               j_in = '0;
               i_in = i_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_OUT_RD: state_in = ST_OUT_LOAD;
         ST_OUT_LOAD: begin
            cmd.out_load = 1'b1;
            state_in     = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (status.rsp_taken) begin
               state_in = ST_OUT_RD;
               if (cell_end) begin
                  i_in     = '0;
                  j_in     = '0;
                  state_in = ST_LOAD;
               end else if (j_ff == nm1) begin
                  j_in = '0;
                  i_in = i_ff + 1'b1;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase

      if (csr_we) begin
         if (csr_index == REG_DIM) begin
            dim_in = csr_data[DIM_CFG_W-1:0];
            li_in  = '0;
            lj_in  = '0;
         end else if (csr_index == REG_TERMS) begin
            terms_in = csr_data[TERMS_CFG_W-1:0];
            li_in    = '0;
            lj_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         dim_ff   <= DIM_CFG_W'(8);
         terms_ff <= TERMS_CFG_W'(8);
         i_ff     <= '0;
         j_ff     <= '0;
         m_ff     <= '0;
         li_ff    <= '0;
         lj_ff    <= '0;
         k_ff     <= '0;
         dcnt_ff  <= '0;
         bank_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         dim_ff   <= dim_in;
         terms_ff <= terms_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         m_ff     <= m_in;
         li_ff    <= li_in;
         lj_ff    <= lj_in;
         k_ff     <= k_in;
         dcnt_ff  <= dcnt_in;
         bank_ff  <= bank_in;
      end
   end

endmodule

// ===== rtl/met_dpath.sv =====
// datapath: matrix stores, multiply-accumulate, serial divider, output register
// depends on met_pkg; steered by met_ctrl
module met_dpath #(
   parameter int MAX_DIM   = 8,
   parameter int MAX_TERMS = 32,
   parameter int FRAC_BITS = 16,
   localparam int CELLS    = MAX_DIM * MAX_DIM,
   localparam int ADDR_W   = (CELLS > 1) ? $clog2(CELLS) : 1,
   localparam int KW       = $clog2(MAX_TERMS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  met_pkg::met_cmd_type          cmd,
   input  logic [ADDR_W-1:0]             load_addr,
   input  logic [ADDR_W-1:0]             cell_addr,
   input  logic [ADDR_W-1:0]             src_raddr,
   input  logic [ADDR_W-1:0]             trm_raddr,
   input  logic                          trm_rbank,
   input  logic                          trm_wbank,
   input  logic [KW-1:0]                 k_value,
   input  logic [met_pkg::DATA_W-1:0]    req_tdata,
   output logic [met_pkg::DATA_W-1:0]    rsp_tdata,
   output logic                          rsp_tlast,
   output logic [0:0]                    rsp_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output met_pkg::met_status_type       status
);
   import met_pkg::*;

   localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

   logic [DATA_W-1:0] src_mem [0:CELLS-1];
   logic [DATA_W-1:0] trm_mem [0:1][0:CELLS-1];
   logic [DATA_W-1:0] sum_mem [0:CELLS-1];

   logic [DATA_W-1:0]  src_rd_ff, trm_rd_ff, sum_rd_ff;
   logic signed [63:0] prod_ff, acc_ff;
   logic [DATA_W-1:0]  quo_ff;
   logic [KW-1:0]      rem_ff;
   logic               neg_ff, sat_ff;
   logic [DATA_W-1:0]  rsp_data_ff;
   logic               rsp_last_ff, rsp_sat_ff, rsp_valid_ff;

   logic signed [63:0] src_x, trm_x, sum_x, init_x, upd_x;
   logic [DATA_W:0]    init_s, acc_s, upd_s;
   logic [DATA_W-1:0]  init_val, mag, q_val;
   logic [KW:0]        div_t;
   logic               div_ge;

   assign src_x  = 64'($signed(src_rd_ff));
   assign trm_x  = 64'($signed(trm_rd_ff));
   assign sum_x  = 64'($signed(sum_rd_ff));
   assign init_x = (cmd.diag ? ONE : 64'sd0) + src_x;
   assign init_s = sat32(init_x);
   assign init_val = cmd.one_term ? (cmd.diag ? ONE[DATA_W-1:0] : '0)
                                  : init_s[DATA_W-1:0];
   assign acc_s  = sat32(acc_ff);
   assign mag    = acc_s[DATA_W-1] ? (~acc_s[DATA_W-1:0] + 1'b1) : acc_s[DATA_W-1:0];
   assign div_t  = {rem_ff, quo_ff[DATA_W-1]};
   assign div_ge = (div_t >= {1'b0, k_value});
   assign q_val  = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign upd_x  = sum_x + 64'($signed(q_val));
   assign upd_s  = sat32(upd_x);

   // stores
   always_ff @(posedge clock) begin
      if (cmd.load_we) begin
         src_mem[load_addr] <= req_tdata;
      end
      if (cmd.init_wr) begin
         trm_mem[trm_wbank][cell_addr] <= src_rd_ff;
      end else if (cmd.upd_wr) begin
         trm_mem[trm_wbank][cell_addr] <= q_val;
      end
      if (cmd.init_wr) begin
         sum_mem[cell_addr] <= init_val;
      end else if (cmd.upd_wr) begin
         sum_mem[cell_addr] <= upd_s[DATA_W-1:0];
      end
      src_rd_ff <= src_mem[src_raddr];
      trm_rd_ff <= trm_mem[trm_rbank][trm_raddr];
      sum_rd_ff <= sum_mem[cell_addr];
   end

   // arithmetic
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= trm_x * src_x;
      end
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (cmd.acc) begin
         acc_ff <= acc_ff + (prod_ff >>> FRAC_BITS);
      end
      if (cmd.div_start) begin
         quo_ff <= mag;
         rem_ff <= '0;
         neg_ff <= acc_s[DATA_W-1];
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[DATA_W-2:0], div_ge};
         rem_ff <= div_ge ? KW'(div_t - {1'b0, k_value}) : div_t[KW-1:0];
      end
      if (cmd.out_load) begin
         rsp_data_ff <= sum_rd_ff;
         rsp_last_ff <= cmd.out_last;
         rsp_sat_ff  <= sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_sat) begin
            sat_ff <= 1'b0;
         end else if ((cmd.init_wr && !cmd.one_term && init_s[DATA_W]) ||
                      (cmd.div_start && acc_s[DATA_W]) ||
                      (cmd.upd_wr && upd_s[DATA_W])) begin
            sat_ff <= 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tdata        = rsp_data_ff;
   assign rsp_tlast        = rsp_last_ff;
   assign rsp_tuser        = rsp_sat_ff;
   assign rsp_tvalid       = rsp_valid_ff;
   assign status.rsp_taken = rsp_valid_ff && rsp_tready;

endmodule

// ===== rtl/matrix_exponential_taylor.sv =====
// top level of the matrix exponential block (truncated taylor series, fixed point)
// depends on met_pkg, met_ctrl and met_dpath
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  element
//   rsp      out        rsp_tvalid/rsp_tready  value, last (tlast), saturated (tuser)
//   csr      in         csr_valid/csr_ready    register index, write data
//
// loading takes one cycle per entry; the last entry starts the computation
// computation: sum and first term are set up entry by entry, then each further term
// comes from the single shared multiplier and the one-bit-per-cycle divider
// results leave one at a time; each waits for rsp_tready before the next is read
// no request is taken while computing or emitting; reset is synchronous
module matrix_exponential_taylor #(
   parameter int MAX_DIM   = 8,
   parameter int MAX_TERMS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [met_pkg::DATA_W-1:0]        req_tdata,   // element
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [met_pkg::DATA_W-1:0]        rsp_tdata,   // value
   output logic                              rsp_tlast,
   output logic [0:0]                        rsp_tuser,   // saturated
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [met_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [met_pkg::CSR_DATA_W-1:0]    csr_data
);
   import met_pkg::*;

   localparam int CELLS  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int KW     = $clog2(MAX_TERMS + 1);

   met_cmd_type       cmd;
   met_status_type    status;
   logic [ADDR_W-1:0] load_addr, cell_addr, src_raddr, trm_raddr;
   logic              trm_rbank, trm_wbank;
   logic [KW-1:0]     k_value;

   met_ctrl #(
      .MAX_DIM   (MAX_DIM),
      .MAX_TERMS (MAX_TERMS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .status     (status),
      .cmd        (cmd),
      .load_addr  (load_addr),
      .cell_addr  (cell_addr),
      .src_raddr  (src_raddr),
      .trm_raddr  (trm_raddr),
      .trm_rbank  (trm_rbank),
      .trm_wbank  (trm_wbank),
      .k_value    (k_value)
   );

   met_dpath #(
      .MAX_DIM   (MAX_DIM),
      .MAX_TERMS (MAX_TERMS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .load_addr  (load_addr),
      .cell_addr  (cell_addr),
      .src_raddr  (src_raddr),
      .trm_raddr  (trm_raddr),
      .trm_rbank  (trm_rbank),
      .trm_wbank  (trm_wbank),
      .k_value    (k_value),
      .req_tdata  (req_tdata),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status)
   );

endmodule
